// ===== rtl/salted_triple_sha1_hash_top_defines.svh =====
// ----------------------------------------------------------------------------
// Salted triple SHA-1 hash: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SALTED_TRIPLE_SHA1_HASH_TOP_DEFINES_SVH
`define SALTED_TRIPLE_SHA1_HASH_TOP_DEFINES_SVH

// Antecedent leads to consequent after the given delay.
`define STSH_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##dly (cons)) else $error(msg);

// Consequent must have held the given delay before the antecedent.
`define STSH_ASSERT_PAST(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> $past((cons), dly)) else $error(msg);

`endif

// ===== rtl/stsh_pkg.sv =====
// ----------------------------------------------------------------------------
// Salted triple SHA-1 hash: package
// Item types, register indexes and SHA-1 helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package stsh_pkg;

  localparam int unsigned Rounds      = 80;
  localparam int unsigned Passes      = 5;
  // each compression: one register per round plus the final add
  localparam int unsigned PipeLat     = Passes * (Rounds + 1) + 1;
  localparam int unsigned PassMaxBytes = 32;
  localparam int unsigned SaltBytes   = 40;
  localparam int unsigned CfgIdxW     = 4;

  localparam logic [159:0] ShaIv = 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SALT_0   = 4'd0,
    CFG_SALT_1   = 4'd1,
    CFG_SALT_2   = 4'd2,
    CFG_SALT_3   = 4'd3,
    CFG_SALT_4   = 4'd4,
    CFG_TARGET_0 = 4'd5,
    CFG_TARGET_1 = 4'd6,
    CFG_TARGET_2 = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] pass_bytes_0_7;
    logic [63:0] pass_bytes_8_15;
    logic [63:0] pass_bytes_16_23;
    logic [63:0] pass_bytes_24_31;
    logic [5:0]  pass_length;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_bits_159_96;
    logic [63:0] digest_bits_95_32;
    logic [31:0] digest_bits_31_0;
    logic        matches_target;
  } out_item_t;

  // one round stage: working variables, chaining value, schedule window, sideband
  typedef struct packed {
    logic [159:0] s;
    logic [159:0] h;
    logic [511:0] w;
    logic [159:0] ctx;
  } stage_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // one SHA-1 round on {a,b,c,d,e}
  function automatic logic [159:0] sha1_round(input logic [159:0] s, input logic [31:0] w,
                                              input int unsigned t);
    logic [31:0] a, b, c, d, e, f, k, tmp;
    a = s[159:128]; b = s[127:96]; c = s[95:64]; d = s[63:32]; e = s[31:0];
    if (t < 20) begin
      f = (b & c) | (~b & d); k = 32'h5A827999;
    end else if (t < 40) begin
      f = b ^ c ^ d; k = 32'h6ED9EBA1;
    end else if (t < 60) begin
      f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d; k = 32'hCA62C1D6;
    end
    tmp = rotl(a, 5) + f + e + k + w;
    sha1_round = {tmp, a, rotl(b, 30), c, d};
  endfunction

  // shift the 16-word schedule window by one word; word 0 is the top
  function automatic logic [511:0] sched_next(input logic [511:0] win);
    logic [31:0] w0, w2, w8, w13, nw;
    w0  = win[511:480];
    w2  = win[511-64  -: 32];
    w8  = win[511-256 -: 32];
    w13 = win[511-416 -: 32];
    nw  = rotl(w13 ^ w8 ^ w2 ^ w0, 1);
    sched_next = {win[479:0], nw};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    hex_char = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
  endfunction

  // 20-byte digest to 40 lower-case ASCII digits, high nibble first
  function automatic logic [319:0] hex_digest(input logic [159:0] d);
    logic [319:0] r;
    for (int i = 0; i < 40; i++) begin
      r[319-8*i -: 8] = hex_char(d[159-4*i -: 4]);
    end
    hex_digest = r;
  endfunction

  // padded single block of the password
  function automatic logic [511:0] pass_block(input in_item_t it);
    logic [255:0] p;
    logic [5:0]   len;
    logic [511:0] r;
    p   = {it.pass_bytes_0_7, it.pass_bytes_8_15, it.pass_bytes_16_23, it.pass_bytes_24_31};
    len = (it.pass_length > 6'(PassMaxBytes)) ? 6'(PassMaxBytes) : it.pass_length;
    r   = '0;
    for (int i = 0; i < 56; i++) begin
      if (i < PassMaxBytes && 6'(i) < len) begin
        r[511-8*i -: 8] = p[255-8*i -: 8];
      end else if (6'(i) == len) begin
        r[511-8*i -: 8] = 8'h80;
      end
    end
    r[63:0] = {55'd0, len, 3'd0};
    pass_block = r;
  endfunction

  // first block of salt . hex(d)
  function automatic logic [511:0] salt_block(input logic [319:0] salt,
                                              input logic [159:0] d);
    logic [319:0] hx;
    hx = hex_digest(d);
    salt_block = {salt, hx[319:128]};
  endfunction

  // second block: remaining digits, padding, 640-bit length
  function automatic logic [511:0] tail_block(input logic [159:0] d);
    logic [319:0] hx;
    hx = hex_digest(d);
    tail_block = {hx[127:0], 8'h80, 312'd0, 64'd640};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stsh_sha1_pipe.sv =====
// ----------------------------------------------------------------------------
// SHA-1 compression pipeline
// One round per stage, 80 stages plus a final add; takes a block every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stsh_sha1_pipe import stsh_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [159:0] in_h_i,
  input  logic [511:0] in_block_i,
  input  logic [159:0] in_ctx_i,
  output logic         out_valid_o,
  output logic [159:0] out_h_o,
  output logic [159:0] out_ctx_o
);

  logic   valid_q [Rounds];
  stage_t st_q    [Rounds];
  logic         fin_valid_q;
  logic [159:0] fin_h_q;
  logic [159:0] fin_ctx_q;

  // round stages
  for (genvar t = 0; t < Rounds; t++) begin : g_round
    stage_t src, nxt;
    logic   src_v;
    if (t == 0) begin : g_first
      assign src   = '{s: in_h_i, h: in_h_i, w: in_block_i, ctx: in_ctx_i};
      assign src_v = in_valid_i;
    end else begin : g_next
      assign src   = st_q[t-1];
      assign src_v = valid_q[t-1];
    end
    assign nxt.s   = sha1_round(src.s, src.w[511:480], t);
    assign nxt.h   = src.h;
    assign nxt.w   = sched_next(src.w);
    assign nxt.ctx = src.ctx;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[t] <= 1'b0;
      end else begin
        valid_q[t] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[t] <= nxt;
    end
  end

  // feed-forward add of the chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else begin
      fin_valid_q <= valid_q[Rounds-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 5; i++) begin
      fin_h_q[159-32*i -: 32] <= st_q[Rounds-1].h[159-32*i -: 32] +
                                 st_q[Rounds-1].s[159-32*i -: 32];
    end
    fin_ctx_q <= st_q[Rounds-1].ctx;
  end

  assign out_valid_o = fin_valid_q;
  assign out_h_o     = fin_h_q;
  assign out_ctx_o   = fin_ctx_q;

endmodule

`default_nettype wire

// ===== rtl/salted_triple_sha1_hash_top.sv =====
// ----------------------------------------------------------------------------
// Salted triple SHA-1 hash: top level
// sha1(salt . hex(sha1(salt . hex(sha1(password))))) with target compare.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  command   in         start_i & !busy_o            item_i (in_item_t)
//  result    out        result_valid_o, one cycle    result_o (out_item_t)
//  config    in         cfg_valid_i & cfg_ready_o    cfg_index_i, cfg_data_i
//
// Five SHA-1 compressions in a row, each 81 register stages; one more register
// holds the result.
// A new item is taken every cycle; busy_o stays low.
// Reset clears the valid bits and the configuration registers; there is no clearing pass.
// Results cannot be stalled, so nothing in the pipe ever waits.
`default_nettype none
`include "salted_triple_sha1_hash_top_defines.svh"

module salted_triple_sha1_hash_top import stsh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  in_item_t           item_i,
  output logic               result_valid_o,
  output out_item_t          result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  logic [63:0]  salt_q [5];
  logic [63:0]  tgt0_q, tgt1_q;
  logic [31:0]  tgt2_q;
  logic [319:0] salt;
  logic [159:0] target;
  logic         in_acc;

  logic         v   [Passes];
  logic [159:0] h   [Passes];
  logic [159:0] ctx [Passes];

  logic       res_valid_q;
  out_item_t  res_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = start_i && !busy_o;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) salt_q[i] <= '0;
      tgt0_q <= '0;
      tgt1_q <= '0;
      tgt2_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SALT_0:   salt_q[0] <= cfg_data_i;
        CFG_SALT_1:   salt_q[1] <= cfg_data_i;
        CFG_SALT_2:   salt_q[2] <= cfg_data_i;
        CFG_SALT_3:   salt_q[3] <= cfg_data_i;
        CFG_SALT_4:   salt_q[4] <= cfg_data_i;
        CFG_TARGET_0: tgt0_q    <= cfg_data_i;
        CFG_TARGET_1: tgt1_q    <= cfg_data_i;
        CFG_TARGET_2: tgt2_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign salt   = {salt_q[0], salt_q[1], salt_q[2], salt_q[3], salt_q[4]};
  assign target = {tgt0_q, tgt1_q, tgt2_q};

  // hash of the password
  stsh_sha1_pipe u_pass (
    .clk_i, .rst_ni,
    .in_valid_i (in_acc),
    .in_h_i     (ShaIv),
    .in_block_i (pass_block(item_i)),
    .in_ctx_i   ('0),
    .out_valid_o(v[0]), .out_h_o(h[0]), .out_ctx_o(ctx[0])
  );

  // second hash, first block: salt and leading hex digits
  stsh_sha1_pipe u_mid_a (
    .clk_i, .rst_ni,
    .in_valid_i (v[0]),
    .in_h_i     (ShaIv),
    .in_block_i (salt_block(salt, h[0])),
    .in_ctx_i   (h[0]),
    .out_valid_o(v[1]), .out_h_o(h[1]), .out_ctx_o(ctx[1])
  );

  // second hash, tail block
  stsh_sha1_pipe u_mid_b (
    .clk_i, .rst_ni,
    .in_valid_i (v[1]),
    .in_h_i     (h[1]),
    .in_block_i (tail_block(ctx[1])),
    .in_ctx_i   ('0),
    .out_valid_o(v[2]), .out_h_o(h[2]), .out_ctx_o(ctx[2])
  );

  // outer hash, first block
  stsh_sha1_pipe u_out_a (
    .clk_i, .rst_ni,
    .in_valid_i (v[2]),
    .in_h_i     (ShaIv),
    .in_block_i (salt_block(salt, h[2])),
    .in_ctx_i   (h[2]),
    .out_valid_o(v[3]), .out_h_o(h[3]), .out_ctx_o(ctx[3])
  );

  // outer hash, tail block
  stsh_sha1_pipe u_out_b (
    .clk_i, .rst_ni,
    .in_valid_i (v[3]),
    .in_h_i     (h[3]),
    .in_block_i (tail_block(ctx[3])),
    .in_ctx_i   (ctx[0] ^ ctx[2] ^ ctx[4]),
    .out_valid_o(v[4]), .out_h_o(h[4]), .out_ctx_o(ctx[4])
  );

  // result register with target compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= v[4];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.digest_bits_159_96 <= h[4][159:96];
    res_q.digest_bits_95_32  <= h[4][95:32];
    res_q.digest_bits_31_0   <= h[4][31:0];
    res_q.matches_target     <= (h[4] == target);
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // every accepted item yields exactly one result, every result has an item, and no item is lost between hashes
  `STSH_ASSERT_DELAY(a_item_to_result, in_acc, 406, result_valid_o, "item lost in pipe")
  `STSH_ASSERT_PAST(a_result_from_item, result_valid_o, 406, in_acc, "result without item")
  `STSH_ASSERT_DELAY(a_pass_to_mid, v[0], 81, v[1], "second hash lost its item")

endmodule

`default_nettype wire
